// File: sv/hpa_pkg.sv
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared types, codes and sizes of the handle pool allocator.
// ----------------------------------------------------------------------------
package hpa_pkg;

  localparam int HANDLE_W      = 8;
  localparam int HANDLE_SPACE  = 1 << HANDLE_W;
  localparam int POOL_SIZE_DEF = 256;

  // request kinds
  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_TRY     = 2'd1;
  localparam logic [1:0] FN_DEALLOC = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK            = 2'd0;
  localparam logic [1:0] STAT_NONE_FREE     = 2'd1;
  localparam logic [1:0] STAT_NOT_ALLOCATED = 2'd2;
  localparam logic [1:0] STAT_EXHAUSTED     = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

// File: sv/hpa_req_if.sv
// ----------------------------------------------------------------------------
// hpa_req_if
// Request channel: request kind and the handle to release.
// ----------------------------------------------------------------------------
interface hpa_req_if
  import hpa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [HANDLE_W-1:0] release_handle;

  modport source (output valid, output func, output release_handle, input ready);
  modport sink   (input valid, input func, input release_handle, output ready);
endinterface

// File: sv/hpa_rsp_if.sv
// ----------------------------------------------------------------------------
// hpa_rsp_if
// Result channel: granted handle and status.
// ----------------------------------------------------------------------------
interface hpa_rsp_if
  import hpa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] granted_handle;
  logic [1:0]          status;

  modport source (output valid, output granted_handle, output status, input ready);
  modport sink   (input valid, input granted_handle, input status, output ready);
endinterface

// File: sv/handle_pool_allocator.sv
// ----------------------------------------------------------------------------
// handle_pool_allocator
// Fixed pool of handles with a first-in first-out free list and in-use map.
// ----------------------------------------------------------------------------
// At acceptance the free list head and the in-use bit of the released handle
// are read from their RAMs through their registered read ports, and in the
// execute state the result is formed, the RAMs and pointers are written and the
// result word goes to the output register. No new request is taken while one
// executes; a stalled output holds the block in its execute state. The in-use
// map needs no clearing pass: only entries below the mint count are ever
// trusted, and each of those was written when its handle was minted. Handles
// are 8 bits wide, so with a pool above 256 only handles 0 to 255 can be
// released and queued.
module handle_pool_allocator
  import hpa_pkg::*;
#(
  parameter int POOL_SIZE = POOL_SIZE_DEF
) (
  input  logic clk,
  input  logic rst_n,
  hpa_req_if.sink   in_ch,
  hpa_rsp_if.source out_ch
);

  localparam int MAP_DEPTH = (POOL_SIZE < HANDLE_SPACE) ? POOL_SIZE : HANDLE_SPACE;
  localparam int IDX_W     = $clog2(MAP_DEPTH);
  localparam int CNT_W     = $clog2(MAP_DEPTH + 1);
  localparam int MINT_W    = $clog2(POOL_SIZE + 1);

  state_t state_r, state_nxt;

  logic [1:0]          func_r;
  logic [HANDLE_W-1:0] rel_r;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [IDX_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [MINT_W-1:0]   minted_r, minted_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [HANDLE_W-1:0] granted_r, granted_nxt;
  logic [1:0]          status_r, status_nxt;

  logic                in_acc;
  logic                done;
  logic [HANDLE_W-1:0] q_rdata;
  logic                map_rdata;
  logic                q_we;
  logic                map_we;
  logic [IDX_W-1:0]    map_waddr;
  logic                map_wdata;
  logic                rel_in_use;
  logic                dealloc_ok;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(MAP_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign done        = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.granted_handle = granted_r;
  assign out_ch.status         = status_r;

  // free list: handles waiting for reuse
  hpa_ram #(.WIDTH(HANDLE_W), .DEPTH(MAP_DEPTH)) u_free_q (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r),
    .wdata (rel_r),
    .re    (in_acc),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  // in-use map, trusted only below the mint count
  hpa_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_in_use (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (in_acc),
    .raddr (in_ch.release_handle[IDX_W-1:0]),
    .rdata (map_rdata)
  );

  // out-of-range handles short out before the narrow compare
  assign rel_in_use = (32'(rel_r) < POOL_SIZE) && (MINT_W'(rel_r) < minted_r) && map_rdata;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // execute: result word, ram writes, pointer updates
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    minted_nxt    = minted_r;
    granted_nxt   = granted_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    q_we          = 1'b0;
    map_we        = 1'b0;
    map_waddr     = rel_r[IDX_W-1:0];
    map_wdata     = 1'b0;
    dealloc_ok    = 1'b0;
    if (done) begin
      out_valid_nxt = 1'b1;
      granted_nxt   = '0;
      status_nxt    = STAT_OK;
      unique case (func_r) inside
        FN_ALLOC, FN_TRY: begin
          if (count_r != '0) begin
            granted_nxt = q_rdata;
            head_nxt    = wrap_inc(head_r);
            count_nxt   = count_r - 1'b1;
            map_we      = 1'b1;
            map_waddr   = q_rdata[IDX_W-1:0];
            map_wdata   = 1'b1;
          end else if (func_r == FN_TRY) begin
            status_nxt = STAT_NONE_FREE;
          end else if (32'(minted_r) >= POOL_SIZE) begin
            status_nxt = STAT_EXHAUSTED;
          end else begin
            granted_nxt = HANDLE_W'(minted_r);
            minted_nxt  = minted_r + 1'b1;
            // handles past the map can never be released
            map_we      = (32'(minted_r) < MAP_DEPTH);
            map_waddr   = minted_r[IDX_W-1:0];
            map_wdata   = 1'b1;
          end
        end
        FN_DEALLOC: begin
          if (!rel_in_use) begin
            status_nxt = STAT_NOT_ALLOCATED;
          end else begin
            // only in-use handles get queued, so the list cannot overflow
            dealloc_ok = 1'b1;
            map_we     = 1'b1;
            q_we       = 1'b1;
            tail_nxt   = wrap_inc(tail_r);
            count_nxt  = count_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      minted_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      minted_r    <= minted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_ch.func;
      rel_r  <= in_ch.release_handle;
    end
    granted_r <= granted_nxt;
    status_r  <= status_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAP_DEPTH)
    else $error("free list count beyond capacity");

  a_mint_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(minted_r) <= POOL_SIZE)
    else $error("mint count beyond pool size");

  a_dealloc_queues: assert property (@(posedge clk) disable iff (!rst_n)
    dealloc_ok |=> (count_r == $past(count_r) + 1'b1) && out_valid_r &&
                   (status_r == STAT_OK))
    else $error("released handle not queued");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_EXEC) && !in_ch.ready)
    else $error("request accepted while another executes");

endmodule

// File: sv/hpa_ram.sv
// ----------------------------------------------------------------------------
// hpa_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: tb/tb_handle_pool_allocator.sv
// ----------------------------------------------------------------------------
// tb_handle_pool_allocator
// Self-checking bench for the handle pool allocator. A clocked driver sends
// allocate, try-allocate, deallocate and unused request words from a pending
// queue; a shadow pool (free list, held map, mint count) predicts each grant
// when its request is accepted; a clocked monitor checks every result word in
// order. Directed requests come first, then random phases that fill the pool
// to exhaustion, drain it and mix both, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_handle_pool_allocator;
  import hpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SIZE    = POOL_SIZE_DEF;
  localparam int RANDOM_ITEMS = 1100;
  localparam int IDLE_PCT     = 17;
  localparam int QUIET_FROM   = 1500;
  localparam int QUIET_TO     = 2500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]          func;
    logic [HANDLE_W-1:0] release_handle;
    logic                from_held;
  } request_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] granted_handle;
    logic [1:0]          status;
  } grant_t;

  logic clk;
  logic rst_n;
  int   cycle = 0;
  int   errors = 0;
  logic quiet;

  hpa_req_if req_ch ();
  hpa_rsp_if rsp_ch ();

  handle_pool_allocator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  // shadow pool
  logic [HANDLE_W-1:0] free_list[$];
  bit                  held_map[POOL_SIZE];
  int                  minted = 0;

  request_t pending_q[$];
  grant_t   grant_q[$];

  always #5 clk = ~clk;

  assign quiet = (cycle >= QUIET_FROM) && (cycle < QUIET_TO);

  function automatic grant_t serve_request(logic [1:0] func, logic [HANDLE_W-1:0] rel);
    grant_t              g;
    logic [HANDLE_W-1:0] h;
    g = '0;
    g.status = STAT_OK;
    case (func) inside
      FN_ALLOC, FN_TRY: begin
        if (free_list.size() != 0) begin
          h = free_list.pop_front();
          held_map[h] = 1'b1;
          g.granted_handle = h;
        end else if (func == FN_TRY) begin
          g.status = STAT_NONE_FREE;
        end else if (minted >= POOL_SIZE) begin
          g.status = STAT_EXHAUSTED;
        end else begin
          h = minted[HANDLE_W-1:0];
          held_map[h] = 1'b1;
          minted++;
          g.granted_handle = h;
        end
      end
      FN_DEALLOC: begin
        if (!held_map[rel]) begin
          g.status = STAT_NOT_ALLOCATED;
        end else begin
          held_map[rel] = 1'b0;
          free_list.push_back(rel);
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  task automatic add_request(logic [1:0] func, logic [HANDLE_W-1:0] rel, logic from_held);
    request_t rq;
    rq.func = func;
    rq.release_handle = rel;
    rq.from_held = from_held;
    pending_q.push_back(rq);
  endtask

  // request driver; predicts at acceptance, picks held handles at launch
  always @(posedge clk) begin : req_driver
    request_t            rq;
    logic [HANDLE_W-1:0] held_list[$];
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        grant_q.push_back(serve_request(req_ch.func, req_ch.release_handle));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          rq = pending_q.pop_front();
          if (rq.from_held) begin
            held_list.delete();
            for (int i = 0; i < POOL_SIZE; i++) begin
              if (held_map[i]) held_list.push_back(i[HANDLE_W-1:0]);
            end
            if (held_list.size() != 0) begin
              rq.release_handle = held_list[$urandom_range(held_list.size() - 1)];
            end
          end
          req_ch.valid          <= 1'b1;
          req_ch.func           <= rq.func;
          req_ch.release_handle <= rq.release_handle;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready
  always @(posedge clk) begin : rsp_monitor
    grant_t exp_g;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result word: granted_handle %0d status %0d",
                 rsp_ch.granted_handle, rsp_ch.status);
          errors++;
        end else begin
          exp_g = grant_q.pop_front();
          if (rsp_ch.granted_handle !== exp_g.granted_handle) begin
            $error("granted_handle mismatch: expected %0d, actual %0d",
                   exp_g.granted_handle, rsp_ch.granted_handle);
            errors++;
          end
          if (rsp_ch.status !== exp_g.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   exp_g.status, rsp_ch.status);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("handle_pool_allocator regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int         served;
    int         seg_len;
    int         alloc_pct;
    int         try_pct;
    int         held_pct;
    int         bad_pct;
    int         pick;
    logic [1:0] func;
    logic       from_held;

    clk                   = 1'b0;
    rst_n                 = 1'b0;
    req_ch.valid          = 1'b0;
    req_ch.func           = FN_ALLOC;
    req_ch.release_handle = '0;
    rsp_ch.ready          = 1'b0;

    // empty pool, bad releases, unused kind, fifo reuse order, double free
    add_request(FN_TRY,     8'd0,   1'b0);
    add_request(FN_DEALLOC, 8'd0,   1'b0);
    add_request(FN_DEALLOC, 8'd255, 1'b0);
    add_request(FN_UNUSED,  8'hAA,  1'b0);
    add_request(FN_ALLOC,   8'hFF,  1'b0);
    add_request(FN_ALLOC,   8'd0,   1'b0);
    add_request(FN_ALLOC,   8'd0,   1'b0);
    add_request(FN_DEALLOC, 8'd1,   1'b0);
    add_request(FN_DEALLOC, 8'd1,   1'b0);
    add_request(FN_DEALLOC, 8'd0,   1'b0);
    add_request(FN_TRY,     8'd0,   1'b0);
    add_request(FN_ALLOC,   8'd0,   1'b0);
    add_request(FN_ALLOC,   8'd0,   1'b0);
    add_request(FN_TRY,     8'hFF,  1'b0);
    add_request(FN_UNUSED,  8'h55,  1'b0);
    add_request(FN_DEALLOC, 8'd2,   1'b0);
    add_request(FN_DEALLOC, 8'd3,   1'b0);
    add_request(FN_ALLOC,   8'd0,   1'b0);
    add_request(FN_TRY,     8'd0,   1'b0);
    add_request(FN_DEALLOC, 8'd200, 1'b0);

    // random phases; the first one mints the whole pool and runs into exhaustion
    served = 0;
    while (served < RANDOM_ITEMS) begin
      if (served == 0) begin
        seg_len = 500; alloc_pct = 75; try_pct = 5; held_pct = 12; bad_pct = 5;
      end else begin
        seg_len = $urandom_range(150, 50);
        case ($urandom_range(2))
          0: begin alloc_pct = 70; try_pct = 8;  held_pct = 12; bad_pct = 6;  end
          1: begin alloc_pct = 10; try_pct = 15; held_pct = 60; bad_pct = 10; end
          default: begin alloc_pct = 35; try_pct = 20; held_pct = 30; bad_pct = 10; end
        endcase
      end
      repeat (seg_len) begin
        pick = $urandom_range(99);
        from_held = 1'b0;
        if (pick < alloc_pct) begin
          func = FN_ALLOC;
        end else if (pick < alloc_pct + try_pct) begin
          func = FN_TRY;
        end else if (pick < alloc_pct + try_pct + held_pct) begin
          func = FN_DEALLOC;
          from_held = 1'b1;
        end else if (pick < alloc_pct + try_pct + held_pct + bad_pct) begin
          func = FN_DEALLOC;
        end else begin
          func = FN_UNUSED;
        end
        add_request(func, HANDLE_W'($urandom_range(HANDLE_SPACE - 1)), from_held);
        if (func != FN_UNUSED) served++;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || req_ch.valid || grant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("handle_pool_allocator regression: pass");
    end else begin
      $display("handle_pool_allocator regression: fail");
    end
    $finish;
  end

endmodule
